// ===== design/pulse_width_key_decoder_unit_defines.svh =====
// Assertion helpers shared by the decoder modules.
// Both macros expect clk and rst_n in scope.
`ifndef PULSE_WIDTH_KEY_DECODER_UNIT_DEFINES_SVH
`define PULSE_WIDTH_KEY_DECODER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define PWKD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A cause that must be followed by an effect in the following cycle.
`define PWKD_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);

`endif

// ===== design/pwkd_pkg.sv =====
package pwkd_pkg;

  localparam int FRAME_PULSES = 100;
  localparam int SYMBOLS      = 8;

  localparam int DATA_PULSES  = SYMBOLS * 4;
  // A start may begin no later than pulse index START_LIMIT - 4.
  localparam int START_LIMIT  = FRAME_PULSES - (SYMBOLS + 1) * 4 + 3;

  localparam int IDX_W   = $clog2(FRAME_PULSES + 1);
  localparam int DPC_W   = $clog2(DATA_PULSES + 1);
  localparam int GRP_W   = 3;
  localparam int WIDTH_W = 10;
  localparam int CODE_W  = 16;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 2'd2;

  localparam logic [WIDTH_W-1:0] RESET_LONG_THRESHOLD = 10'd70;
  localparam logic [CNT_W-1:0]   RESET_CONFIRM_COUNT  = 4'd3;
  localparam logic [CNT_W-1:0]   RESET_MAX_ATTEMPTS   = 4'd10;

  typedef enum logic [1:0] {
    ST_FAILED    = 2'd0,
    ST_DECODED   = 2'd1,
    ST_CONFIRMED = 2'd2,
    ST_GAVE_UP   = 2'd3
  } status_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] long_threshold;
    logic [CNT_W-1:0]   confirm_count;
    logic [CNT_W-1:0]   max_attempts;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [CODE_W-1:0] code;
  } frame_end_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic [CODE_W-1:0] frame_code;
    status_t           status;
  } result_t;

endpackage

// ===== design/pwkd_frame.sv =====
`include "pulse_width_key_decoder_unit_defines.svh"

module pwkd_frame (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [pwkd_pkg::WIDTH_W-1:0] pulse_width,
  input  logic                        timed_out,
  input  logic [pwkd_pkg::WIDTH_W-1:0] long_threshold,
  output pwkd_pkg::frame_end_t        frame_end
);
  import pwkd_pkg::*;

  logic [IDX_W-1:0]  pulse_index_r, pulse_index_nxt;
  logic [2:0]        long_history_r, long_history_nxt;
  logic              start_seen_r, start_seen_nxt;
  logic [DPC_W-1:0]  data_cnt_r, data_cnt_nxt;
  logic [CODE_W-1:0] code_acc_r, code_acc_nxt;

  logic              is_long;
  logic              is_short;
  logic [GRP_W-1:0]  group;
  logic [1:0]        pos;

  assign is_long  = pulse_width > long_threshold;
  assign is_short = pulse_width < long_threshold;
  assign group    = GRP_W'(data_cnt_r >> 2);
  assign pos      = data_cnt_r[1:0];

  always_comb begin
    pulse_index_nxt  = pulse_index_r;
    long_history_nxt = long_history_r;
    start_seen_nxt   = start_seen_r;
    data_cnt_nxt     = data_cnt_r;
    code_acc_nxt     = code_acc_r;
    frame_end        = '0;
    if (fire) begin
      if (timed_out) begin
        frame_end.valid = 1'b1;
        pulse_index_nxt  = '0;
        long_history_nxt = '0;
        start_seen_nxt   = 1'b0;
        data_cnt_nxt     = '0;
        code_acc_nxt     = '0;
      end else begin
        if (start_seen_r) begin
          if (data_cnt_r < DPC_W'(DATA_PULSES)) begin
            if (is_long) begin
              code_acc_nxt = code_acc_r | (CODE_W'(pos) << {group, 1'b0});
            end
            data_cnt_nxt = data_cnt_r + 1'b1;
          end
        end else if (pulse_index_r >= IDX_W'(3) && long_history_r == 3'b111 && is_short &&
                     pulse_index_r < IDX_W'(START_LIMIT)) begin
          start_seen_nxt = 1'b1;
          data_cnt_nxt   = '0;
          code_acc_nxt   = '0;
        end
        long_history_nxt = {long_history_r[1:0], is_long};
        pulse_index_nxt  = pulse_index_r + 1'b1;
        if (pulse_index_nxt >= IDX_W'(FRAME_PULSES)) begin
          frame_end.valid  = 1'b1;
          frame_end.ok     = start_seen_nxt;
          frame_end.code   = code_acc_nxt;
          pulse_index_nxt  = '0;
          long_history_nxt = '0;
          start_seen_nxt   = 1'b0;
          data_cnt_nxt     = '0;
          code_acc_nxt     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_index_r  <= '0;
      long_history_r <= '0;
      start_seen_r   <= 1'b0;
      data_cnt_r     <= '0;
      code_acc_r     <= '0;
    end else begin
      pulse_index_r  <= pulse_index_nxt;
      long_history_r <= long_history_nxt;
      start_seen_r   <= start_seen_nxt;
      data_cnt_r     <= data_cnt_nxt;
      code_acc_r     <= code_acc_nxt;
    end
  end

  `PWKD_ASSERT_ALWAYS(a_index_in_frame, pulse_index_r < IDX_W'(FRAME_PULSES),
    "pulse index reached the frame length without closing the frame")
  `PWKD_ASSERT_ALWAYS(a_idle_until_start, start_seen_r || (data_cnt_r == '0 && code_acc_r == '0),
    "data collected before a start was found")
  `PWKD_ASSERT_NEXT(a_timeout_clears, fire && timed_out,
    pulse_index_r == '0 && !start_seen_r, "timeout did not clear the frame")

endmodule

// ===== design/pwkd_seq.sv =====
module pwkd_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pwkd_pkg::frame_end_t frame_end,
  input  pwkd_pkg::cfg_t       cfg,
  output logic                 res_valid,
  output pwkd_pkg::result_t    res
);
  import pwkd_pkg::*;

  // The remembered code is either a 16-bit code or the failure mark.
  logic              rem_fail_r, rem_fail_nxt;
  logic [CODE_W-1:0] rem_code_r, rem_code_nxt;
  logic [CNT_W-1:0]  match_cnt_r, match_cnt_nxt;
  logic [CNT_W-1:0]  attempt_cnt_r, attempt_cnt_nxt;

  logic              is_match;
  logic [CNT_W-1:0]  match_upd;
  logic [CNT_W-1:0]  attempt_upd;
  logic              confirmed;

  assign is_match    = frame_end.ok && !rem_fail_r && rem_code_r == frame_end.code;
  assign match_upd   = is_match ? ((match_cnt_r == CNT_MAX) ? match_cnt_r : match_cnt_r + 1'b1)
                                : '0;
  assign attempt_upd = (attempt_cnt_r == CNT_MAX) ? attempt_cnt_r : attempt_cnt_r + 1'b1;
  assign confirmed   = frame_end.ok && match_upd >= cfg.confirm_count;
  assign res_valid   = frame_end.valid;

  always_comb begin
    rem_fail_nxt    = rem_fail_r;
    rem_code_nxt    = rem_code_r;
    match_cnt_nxt   = match_cnt_r;
    attempt_cnt_nxt = attempt_cnt_r;
    res.frame_code  = frame_end.ok ? frame_end.code : '0;
    res.key_code    = confirmed ? frame_end.code : '0;
    res.status      = frame_end.ok ? ST_DECODED : ST_FAILED;
    if (frame_end.valid) begin
      match_cnt_nxt   = match_upd;
      attempt_cnt_nxt = attempt_upd;
      if (!is_match) begin
        rem_fail_nxt = !frame_end.ok;
        rem_code_nxt = frame_end.ok ? frame_end.code : '0;
      end
      if (confirmed || attempt_upd >= cfg.max_attempts) begin
        res.status      = confirmed ? ST_CONFIRMED : ST_GAVE_UP;
        rem_fail_nxt    = 1'b0;
        rem_code_nxt    = '0;
        match_cnt_nxt   = '0;
        attempt_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_fail_r    <= 1'b0;
      rem_code_r    <= '0;
      match_cnt_r   <= '0;
      attempt_cnt_r <= '0;
    end else begin
      rem_fail_r    <= rem_fail_nxt;
      rem_code_r    <= rem_code_nxt;
      match_cnt_r   <= match_cnt_nxt;
      attempt_cnt_r <= attempt_cnt_nxt;
    end
  end

endmodule

// ===== design/pwkd_outbuf.sv =====
`include "pulse_width_key_decoder_unit_defines.svh"

module pwkd_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pwkd_pkg::result_t push_data,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output pwkd_pkg::result_t out_data
);
  import pwkd_pkg::*;

  // Two entries: the head drives the output, the second catches a result
  // that arrives while the head is still waiting.
  logic [1:0] cnt_r, cnt_nxt;
  result_t    head_r, head_nxt;
  result_t    tail_r, tail_nxt;
  logic       pop;

  assign has_room  = cnt_r != 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = head_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          head_nxt = push_data;
        end else begin
          tail_nxt = push_data;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      2'b01: begin
        head_nxt = tail_r;
        cnt_nxt  = cnt_r - 1'b1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_nxt = push_data;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  `PWKD_ASSERT_ALWAYS(a_cnt_range, cnt_r != 2'd3, "result queue count out of range")
  `PWKD_ASSERT_ALWAYS(a_no_overflow, !push || cnt_r != 2'd2, "result pushed into a full queue")
  `PWKD_ASSERT_NEXT(a_drain_full, cnt_r == 2'd2 && !push && out_ready, cnt_r == 2'd1,
    "full queue did not drain by one")

endmodule

// ===== design/pulse_width_key_decoder_unit.sv =====
// An input item is held in the input register and fires once the result queue has room;
// a frame end then passes through the frame and sequence logic into the result queue.
// One item is accepted per cycle while the queue has room; each pulse updates the frame
// registers, each frame end the sequence registers; a two-entry queue absorbs stalls.
// Reset (rst_n low at a clock edge) clears frame and sequence state, empties both stages
// and restores long_threshold 70, confirm_count 3 and max_attempts 10.
module pulse_width_key_decoder_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: pulse_width[9:0], zero fill above
  input  logic [pwkd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // tuser: timed_out[0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata: status[1:0], frame_code[17:2], key_code[33:18], zero fill above
  output logic [pwkd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_we,
  input  logic [pwkd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pwkd_pkg::WIDTH_W-1:0]         cfg_wdata
);
  import pwkd_pkg::*;

  cfg_t               cfg_r;
  logic               in_valid_r;
  logic [WIDTH_W-1:0] in_width_r;
  logic               in_timeout_r;

  logic               fire;
  logic               q_room;
  frame_end_t         frame_end;
  logic               res_valid;
  result_t            res;
  result_t            out_res;

  assign fire      = in_valid_r && q_room;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_threshold <= RESET_LONG_THRESHOLD;
      cfg_r.confirm_count  <= RESET_CONFIRM_COUNT;
      cfg_r.max_attempts   <= RESET_MAX_ATTEMPTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_THRESHOLD: cfg_r.long_threshold <= cfg_wdata;
        CFG_CONFIRM_COUNT:  cfg_r.confirm_count  <= cfg_wdata[CNT_W-1:0];
        CFG_MAX_ATTEMPTS:   cfg_r.max_attempts   <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_width_r   <= in_tdata[WIDTH_W-1:0];
      in_timeout_r <= in_tuser;
    end
  end

  pwkd_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .pulse_width    (in_width_r),
    .timed_out      (in_timeout_r),
    .long_threshold (cfg_r.long_threshold),
    .frame_end      (frame_end)
  );

  pwkd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_end (frame_end),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  pwkd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .has_room  (q_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = OUT_TDATA_W'(out_res);

endmodule
